// ===== hw/rtl/unique_id_table_insert_top_defines.svh =====
// Assertion macros for the identifier table block.
// Used by the top level only; no dependencies.
`ifndef UNIQUE_ID_TABLE_INSERT_TOP_DEFINES_SVH
`define UNIQUE_ID_TABLE_INSERT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UITBL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UITBL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/uitbl_pkg.sv =====
// Shared types and constants for the identifier table block.
// No dependencies.
`default_nettype none

package uitbl_pkg;

	localparam int ID_W              = 64;
	localparam int INDEX_W           = 5;
	localparam int COUNT_W           = 6;
	localparam int TABLE_ENTRIES_DEF = 32;

	typedef struct packed {
		logic [ID_W-1:0] device_id;
	} lookup_item_t;

	typedef struct packed {
		logic               already_known;
		logic               was_inserted;
		logic               table_full;
		logic [INDEX_W-1:0] entry_index;
		logic [COUNT_W-1:0] entry_count;
	} result_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic search;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uitbl_chan_if.sv =====
// Valid/ready channel carrying one item per transfer.
// Payload type is a parameter; no other dependencies.
`default_nettype none

interface uitbl_chan_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/uitbl_ctrl.sv =====
// Controller for the identifier table: sequences search and commit.
// Depends on uitbl_pkg.
`default_nettype none

module uitbl_ctrl
	import uitbl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       lookup_valid,
	output logic       lookup_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (lookup_valid) begin
					state_next = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_next = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (status.slot_free) begin
					state_next = lookup_valid ? ST_SEARCH : ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		lookup_ready = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				lookup_ready = 1'b1;
			end
			ST_SEARCH: begin
				cmd.search = 1'b1;
			end
			ST_COMMIT: begin
				lookup_ready = status.slot_free;
				cmd.commit   = status.slot_free;
			end
			default: begin
				lookup_ready = 1'b0;
			end
		endcase
		cmd.load = lookup_valid && lookup_ready;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/uitbl_datapath.sv =====
// Datapath for the identifier table: stored identifiers, parallel compare,
// entry count and result register. Depends on uitbl_pkg.
`default_nettype none

module uitbl_datapath
	import uitbl_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dp_cmd_t         cmd,
	output dp_status_t      status,
	input  logic [ID_W-1:0] device_id,
	output logic            result_valid,
	input  logic            result_ready,
	output result_item_t    result_item
);

	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [ID_W-1:0]          id_store [TABLE_ENTRIES];
	logic [ID_W-1:0]          id_q;
	logic [TABLE_ENTRIES-1:0] match_vec;
	logic [TABLE_ENTRIES-1:0] match_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_next;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         sel_idx;
	logic [31:0]              idx_ext;
	logic [31:0]              cnt_ext;
	logic                     hit;
	logic                     room;
	logic                     insert;
	logic                     out_valid_q;
	result_item_t             out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= device_id;
		end
	end

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cmp
		assign match_vec[k] = (CNT_W'(k) < cnt_q) && (id_store[k] == id_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			match_q <= match_vec;
		end
	end

	// Stored identifiers are distinct, so at most one match bit is set.
	always_comb begin
		hit_idx = '0;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (match_q[k]) begin
				hit_idx = hit_idx | IDX_W'(k);
			end
		end
	end

	assign hit      = |match_q;
	assign room     = cnt_q < CNT_W'(TABLE_ENTRIES);
	assign insert   = !hit && room;
	assign cnt_next = insert ? cnt_q + CNT_W'(1) : cnt_q;
	assign sel_idx  = hit ? hit_idx : (room ? cnt_q[IDX_W-1:0] : '0);
	assign idx_ext  = 32'(sel_idx);
	assign cnt_ext  = 32'(cnt_next);

	always_ff @(posedge clk) begin
		if (cmd.commit && insert) begin
			id_store[cnt_q[IDX_W-1:0]] <= id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.commit) begin
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.already_known <= hit;
			out_q.was_inserted  <= insert;
			out_q.table_full    <= !hit && !room;
			out_q.entry_index   <= idx_ext[INDEX_W-1:0];
			out_q.entry_count   <= cnt_ext[COUNT_W-1:0];
		end
	end

	assign status.slot_free = !out_valid_q || result_ready;
	assign result_valid     = out_valid_q;
	assign result_item      = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/unique_id_table_insert_top.sv =====
// Top level of the identifier table with insert-if-absent.
// Depends on uitbl_pkg, uitbl_chan_if, uitbl_ctrl, uitbl_datapath and the defines header.
`default_nettype none
`include "unique_id_table_insert_top_defines.svh"

// Each identifier on lookup is compared against all stored entries at once, then either
// reported as found, appended at the next free entry, or dropped with table_full when no
// entry is left. One result per identifier. The search state registers the compare
// across every entry; the commit state then writes any new entry and loads the result
// register. The next identifier is taken in the commit cycle, so a new item is accepted
// before the last is through. The result register holds a finished result while the
// next item is taken; a result still held at the next commit stalls that commit until
// it is transferred. The table starts empty after reset; stored entries need no clearing.

module unique_id_table_insert_top
	import uitbl_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	uitbl_chan_if.sink   lookup,
	uitbl_chan_if.source result
);

	dp_cmd_t      cmd;
	dp_status_t   status;
	logic         lookup_ready;
	logic         result_valid;
	result_item_t result_item;
	lookup_item_t lookup_item;

	assign lookup_item    = lookup.payload;
	assign lookup.ready   = lookup_ready;
	assign result.valid   = result_valid;
	assign result.payload = result_item;

	uitbl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_valid (lookup.valid),
		.lookup_ready (lookup_ready),
		.status       (status),
		.cmd          (cmd)
	);

	uitbl_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.device_id    (lookup_item.device_id),
		.result_valid (result_valid),
		.result_ready (result.ready),
		.result_item  (result_item)
	);

	`UITBL_ASSERT_IMP(a_one_outcome, clk, arst_n, result_valid,
		$onehot({result_item.already_known, result_item.was_inserted, result_item.table_full}),
		"result carries other than exactly one outcome")
	`UITBL_ASSERT_IMP(a_commit_slot, clk, arst_n, cmd.commit, !result_valid || result.ready,
		"commit while result register still held")
	`UITBL_ASSERT_NXT(a_load_search, clk, arst_n, cmd.load, cmd.search && !cmd.commit,
		"accepted item not followed by search")

endmodule

`default_nettype wire
